/* rtl/core/tli_pkg.sv */
// Shared types and constants of the table linear interpolator.
package tli_pkg;

  localparam int DATA_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int SLOT_W          = 4;
  localparam int CNT_W           = 5;
  localparam int MAX_ACTIVE      = 16;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int DIFF_W          = DATA_W + 1;
  localparam int PROD_W          = DIFF_W + FRAC_W + 1;
  localparam int DIV_CNT_W       = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BELOW    = 2'd1;
  localparam logic [1:0] REGION_ABOVE    = 2'd2;

  localparam logic [CNT_W-1:0] POINTS_RESET = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_entry;
    logic q_start;
    logic rd;
    logic scan_adv;
    logic set_below;
    logic set_above;
    logic div_init;
    logic div_step;
    logic mul;
    logic fin_interior;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_gt;
    logic at_first;
    logic at_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/tli_if.sv */
// Channel interfaces of the table linear interpolator.
interface tli_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [tli_pkg::SLOT_W-1:0]       entry_index;
  logic signed [tli_pkg::DATA_W-1:0] entry_key;
  logic signed [tli_pkg::DATA_W-1:0] entry_value;
  logic signed [tli_pkg::DATA_W-1:0] query_point;

  modport source (output valid, req_type, entry_index, entry_key, entry_value, query_point,
                  input ready);
  modport sink   (input valid, req_type, entry_index, entry_key, entry_value, query_point,
                  output ready);
endinterface

interface tli_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tli_pkg::DATA_W-1:0] interp_value;
  logic [1:0]                       region;

  modport source (output valid, interp_value, region, input ready);
  modport sink   (input valid, interp_value, region, output ready);
endinterface

interface tli_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tli_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/tli_ctrl.sv */
// Controller state machine of the table linear interpolator.
module tli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_req_type_i,
  output logic          in_ready_o,
  input  tli_pkg::sts_t sts_i,
  output tli_pkg::cmd_t cmd_o
);

  tli_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tli_pkg::ST_IDLE: begin
        if (in_valid_i && in_req_type_i == tli_pkg::REQ_QUERY) state_d = tli_pkg::ST_READ;
      end
      tli_pkg::ST_READ: state_d = tli_pkg::ST_CMP;
      tli_pkg::ST_CMP: begin
        priority if (sts_i.key_gt && sts_i.at_first) begin
          state_d = tli_pkg::ST_FIN;
        end else if (sts_i.key_gt) begin
          state_d = tli_pkg::ST_DIV;
        end else if (sts_i.at_last) begin
          state_d = tli_pkg::ST_FIN;
        end else begin
          state_d = tli_pkg::ST_READ;
        end
      end
      tli_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = tli_pkg::ST_MUL;
      end
      tli_pkg::ST_MUL: state_d = tli_pkg::ST_SUM;
      tli_pkg::ST_SUM: state_d = tli_pkg::ST_FIN;
      tli_pkg::ST_FIN: begin
        if (sts_i.out_free) state_d = tli_pkg::ST_IDLE;
      end
      default: state_d = tli_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tli_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr_entry = (in_req_type_i == tli_pkg::REQ_LOAD);
          cmd_o.q_start  = (in_req_type_i == tli_pkg::REQ_QUERY);
        end
      end
      tli_pkg::ST_READ: cmd_o.rd = 1'b1;
      tli_pkg::ST_CMP: begin
        priority if (sts_i.key_gt && sts_i.at_first) begin
          cmd_o.set_below = 1'b1;
        end else if (sts_i.key_gt) begin
          cmd_o.div_init = 1'b1;
        end else begin
          cmd_o.scan_adv  = 1'b1;
          cmd_o.set_above = sts_i.at_last;
        end
      end
      tli_pkg::ST_DIV: cmd_o.div_step     = 1'b1;
      tli_pkg::ST_MUL: cmd_o.mul          = 1'b1;
      tli_pkg::ST_SUM: cmd_o.fin_interior = 1'b1;
      tli_pkg::ST_FIN: cmd_o.out_load     = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/core/tli_dpath.sv */
// Datapath of the table linear interpolator: table, scan, divider, blend, output register.
module tli_dpath #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tli_pkg::cmd_t                      cmd_i,
  output tli_pkg::sts_t                      sts_o,
  input  logic [tli_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic signed [tli_pkg::DATA_W-1:0]  entry_key_i,
  input  logic signed [tli_pkg::DATA_W-1:0]  entry_value_i,
  input  logic signed [tli_pkg::DATA_W-1:0]  query_point_i,
  input  logic                               cfg_valid_i,
  input  logic [tli_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [tli_pkg::DATA_W-1:0]  interp_value_o,
  output logic [1:0]                         region_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LIM   = (TABLE_DEPTH < tli_pkg::MAX_ACTIVE) ? TABLE_DEPTH : tli_pkg::MAX_ACTIVE;
  localparam logic [tli_pkg::CNT_W-1:0] LIM_C = tli_pkg::CNT_W'(LIM);

  logic signed [tli_pkg::DATA_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [tli_pkg::DATA_W-1:0] val_mem [TABLE_DEPTH];

  logic [tli_pkg::CNT_W-1:0]          points_q, n_active;
  logic [tli_pkg::CNT_W-1:0]          cnt_q;
  logic signed [tli_pkg::DATA_W-1:0]  point_q, key_rd_q, val_rd_q, key_prev_q, val_prev_q;
  logic [tli_pkg::DATA_W-1:0]         rem_q, den_q;
  logic [tli_pkg::FRAC_W-1:0]         quo_q;
  logic [tli_pkg::DIV_CNT_W-1:0]      div_cnt_q;
  logic signed [tli_pkg::DIFF_W-1:0]  diff_q;
  logic signed [tli_pkg::PROD_W-1:0]  prod_q, sum;
  logic signed [tli_pkg::DATA_W-1:0]  res_q;
  logic [1:0]                         region_q;
  logic                               out_valid_q;
  logic signed [tli_pkg::DATA_W-1:0]  out_value_q;
  logic [1:0]                         out_region_q;
  logic                               slot_ok;
  logic [tli_pkg::DATA_W:0]           rem_shl;
  logic [tli_pkg::DATA_W:0]           rem_sub;

  assign slot_ok = (32'(entry_index_i) < TABLE_DEPTH);

  // Table write on load, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && slot_ok) begin
      key_mem[IDX_W'(entry_index_i)] <= entry_key_i;
      val_mem[IDX_W'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.rd) begin
      key_rd_q <= key_mem[IDX_W'(cnt_q)];
      val_rd_q <= val_mem[IDX_W'(cnt_q)];
    end
  end

  always_comb begin
    priority if (points_q == '0) begin
      n_active = tli_pkg::CNT_W'(1);
    end else if (points_q > LIM_C) begin
      n_active = LIM_C;
    end else begin
      n_active = points_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= tli_pkg::POINTS_RESET;
      cnt_q    <= '0;
    end else begin
      if (cfg_valid_i) points_q <= cfg_data_i;
      if (cmd_i.q_start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_adv) begin
        cnt_q <= cnt_q + tli_pkg::CNT_W'(1);
      end
    end
  end

  // Restoring divide step: remainder stays below the divisor
  assign rem_shl = {rem_q, 1'b0};
  assign rem_sub = rem_shl - {1'b0, den_q};

  assign sum = {{2{val_prev_q[tli_pkg::DATA_W-1]}}, val_prev_q, {tli_pkg::FRAC_W{1'b0}}}
               + prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) point_q <= query_point_i;
    if (cmd_i.scan_adv) begin
      key_prev_q <= key_rd_q;
      val_prev_q <= val_rd_q;
    end
    if (cmd_i.div_init) begin
      rem_q     <= point_q - key_prev_q;
      den_q     <= key_rd_q - key_prev_q;
      diff_q    <= tli_pkg::DIFF_W'(val_rd_q) - tli_pkg::DIFF_W'(val_prev_q);
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + tli_pkg::DIV_CNT_W'(1);
      if (!rem_sub[tli_pkg::DATA_W]) begin
        rem_q <= rem_sub[tli_pkg::DATA_W-1:0];
        quo_q <= {quo_q[tli_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shl[tli_pkg::DATA_W-1:0];
        quo_q <= {quo_q[tli_pkg::FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) prod_q <= tli_pkg::PROD_W'($signed({1'b0, quo_q}) * diff_q);
    priority if (cmd_i.set_below) begin
      res_q    <= val_rd_q;
      region_q <= tli_pkg::REGION_BELOW;
    end else if (cmd_i.set_above) begin
      res_q    <= val_rd_q;
      region_q <= tli_pkg::REGION_ABOVE;
    end else if (cmd_i.fin_interior) begin
      res_q    <= sum[tli_pkg::DATA_W+tli_pkg::FRAC_W-1:tli_pkg::FRAC_W];
      region_q <= tli_pkg::REGION_INTERIOR;
    end else begin
      res_q    <= res_q;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_q;
      out_region_q <= region_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Rem_sub sign bit clear means the shifted remainder reached the divisor;
  // the divisor is nonzero, so a set top bit of rem_shl always subtracts.
  assign sts_o.key_gt   = (key_rd_q > point_q);
  assign sts_o.at_first = (cnt_q == '0);
  assign sts_o.at_last  = ((cnt_q + tli_pkg::CNT_W'(1)) == n_active);
  assign sts_o.div_last = (div_cnt_q == {tli_pkg::DIV_CNT_W{1'b1}});
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign region_o       = out_region_q;

endmodule

/* rtl/core/table_linear_interpolator.sv */
// Top level of the table linear interpolator.
// Requests arrive on in_i (valid/ready). A load request (req_type 0) writes
// one breakpoint (entry_key, entry_value) to slot entry_index and gives no
// result; slots at or beyond TABLE_DEPTH are dropped.
// A query request (req_type 1) gives one result on out_o: interp_value and
// a region code (interior, below first key, at or beyond last key).
// A query scans the active keys in order (up to sixteen), reading each key from
// memory and then comparing it; an interior point then runs the restoring
// divider, one multiply and one add, and a final step moves the result into
// the output register once that register is free.
// Only one query is in flight; loads are taken only while idle.
// cfg_i writes points_in_use (always ready); write it only while idle.
// Reset empties the output register and sets points_in_use to one; the
// table contents are undefined until loaded, so load every active slot first.
// If the receiver stalls, the result waits in the output register, the block
// still takes requests, and a further query holds its result until out_o drains.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tli_in_if.sink    in_i,
  tli_out_if.source out_o,
  tli_cfg_if.sink   cfg_i
);

  tli_pkg::cmd_t cmd;
  tli_pkg::sts_t sts;

  // Configuration register is always free to take a write
  assign cfg_i.ready = 1'b1;

  // Sequencing of loads, the key scan, divide and blend
  tli_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.req_type),
    .in_ready_o    (in_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Table memory, arithmetic and the output register
  tli_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_index_i  (in_i.entry_index),
    .entry_key_i    (in_i.entry_key),
    .entry_value_i  (in_i.entry_value),
    .query_point_i  (in_i.query_point),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .interp_value_o (out_o.interp_value),
    .region_o       (out_o.region)
  );

endmodule
